// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the checker files
// no dependencies; expects i_clk and i_rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define KM_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define KM_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/km_pkg.sv =====
// shared constants, codes and widths of the k-means engine
// no dependencies
package km_pkg;

    localparam int KM_MAX_POINTS   = 1024;
    localparam int KM_MAX_CLUSTERS = 8;
    localparam int KM_MAX_DIMS     = 8;

    localparam int OP_W       = 2;
    localparam int ROW_W      = 10;
    localparam int DIM_W      = 3;
    localparam int COORD_W    = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int ITER_W     = 16;
    localparam int CL_W       = 3;

    // magnitude of a 33-bit difference, its square, distance and norm radicand
    localparam int MAG_W  = 33;
    localparam int PROD_W = 2 * MAG_W;
    localparam int DIST_W = PROD_W + 3;
    localparam int RAD_W  = PROD_W;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_POINT    = 2'd0,
        OP_LOAD_CENTROID = 2'd1,
        OP_RUN           = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_POINTS   = 3'd0,
        CFG_NUM_CLUSTERS = 3'd1,
        CFG_NUM_DIMS     = 3'd2,
        CFG_MAX_ITER     = 3'd3,
        CFG_EPSILON      = 3'd4
    } t_cfg_idx;

endpackage

// ===== rtl/core/kmeans_clustering.sv =====
// lloyd k-means engine over signed q16.16 points held in on-chip memories
// depends on km_pkg, km_div, km_isqrt
//
//  channel   | handshake              | payload
//  ----------+------------------------+----------------------------------------------
//  command   | i_start, o_busy        | i_operation, i_row, i_dim, i_coord
//  config    | i_cfg_we               | i_cfg_idx, i_cfg_data
//  result    | o_valid (strobe)       | o_cluster, o_coord_index, o_centroid_value,
//            |                        | o_iterations, o_empty_error, o_last
//
// loads never raise busy
// a run makes passes of assignment over all points and clusters, then per
// cluster, if none is empty, the update and norms (divider and root unit
// are bit-serial), and then emits each centroid coordinate
// reset clears control state only; memory contents are undefined until loaded
// results cannot be stalled: each result strobes for one cycle
module kmeans_clustering #(
    parameter int MAX_POINTS   = km_pkg::KM_MAX_POINTS,
    parameter int MAX_CLUSTERS = km_pkg::KM_MAX_CLUSTERS,
    parameter int MAX_DIMS     = km_pkg::KM_MAX_DIMS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [km_pkg::OP_W-1:0]           i_operation,
    input  logic [km_pkg::ROW_W-1:0]          i_row,
    input  logic [km_pkg::DIM_W-1:0]          i_dim,
    input  logic signed [km_pkg::COORD_W-1:0] i_coord,
    input  logic                              i_cfg_we,
    input  logic [km_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [km_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                              o_valid,
    output logic [km_pkg::CL_W-1:0]           o_cluster,
    output logic [km_pkg::DIM_W-1:0]          o_coord_index,
    output logic signed [km_pkg::COORD_W-1:0] o_centroid_value,
    output logic [km_pkg::ITER_W-1:0]         o_iterations,
    output logic                              o_empty_error,
    output logic                              o_last
);
    import km_pkg::*;

    // index widths
    localparam int PIW = $clog2(MAX_POINTS);
    localparam int CW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int DW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int CNW = $clog2(MAX_POINTS + 1);
    // a cluster sum of up to MAX_POINTS coordinates
    localparam int SW  = COORD_W + PIW;
    localparam int RTW = RAD_W / 2;

    typedef enum logic [17:0] {
        S_IDLE  = 18'b000000000000000001,
        S_DRD   = 18'b000000000000000010,
        S_DSUB  = 18'b000000000000000100,
        S_DMUL  = 18'b000000000000001000,
        S_DACC  = 18'b000000000000010000,
        S_ARD   = 18'b000000000000100000,
        S_AWR   = 18'b000000000001000000,
        S_CHK   = 18'b000000000010000000,
        S_URD   = 18'b000000000100000000,
        S_UOLD  = 18'b000000001000000000,
        S_UDIV  = 18'b000000010000000000,
        S_UNMUL = 18'b000000100000000000,
        S_UNACC = 18'b000001000000000000,
        S_SQO   = 18'b000010000000000000,
        S_SQN   = 18'b000100000000000000,
        S_PEND  = 18'b001000000000000000,
        S_ERD   = 18'b010000000000000000,
        S_EOUT  = 18'b100000000000000000
    } t_state;

    // configuration registers
    logic [10:0]      r_num_points;
    logic [3:0]       r_num_clusters;
    logic [3:0]       r_num_dims;
    logic [ITER_W-1:0] r_max_iter;
    logic [31:0]      r_epsilon;

    // sequencer state
    t_state           r_state;
    logic [PIW-1:0]   r_i;
    logic [CW-1:0]    r_c;
    logic [DW-1:0]    r_j;
    logic [CW-1:0]    r_best;
    logic [CNW-1:0]   r_cnt [MAX_CLUSTERS];
    logic [ITER_W-1:0] r_pass;
    logic             r_empty;
    logic             r_conv;

    // datapath registers
    logic [DIST_W-1:0] r_dist;
    logic [DIST_W-1:0] r_best_dist;
    logic [MAG_W-1:0]  r_mul_a;
    logic [PROD_W-1:0] r_prod;
    logic [RAD_W-1:0]  r_s_old;
    logic [RAD_W-1:0]  r_s_new;
    logic [RTW-1:0]    r_norm_old;
    logic              r_neg;

    // result registers
    logic              r_valid;
    logic [CL_W-1:0]   r_out_cl;
    logic [DIM_W-1:0]  r_out_dim;
    logic [COORD_W-1:0] r_out_val;
    logic              r_out_last;

    // memories: points, current centroids, cluster sums
    logic [COORD_W-1:0] r_pt_mem   [MAX_POINTS << DW];
    logic [COORD_W-1:0] r_cent_mem [MAX_CLUSTERS << DW];
    logic [SW-1:0]      r_sum_mem  [MAX_CLUSTERS << DW];
    logic [COORD_W-1:0] r_pt_q;
    logic [COORD_W-1:0] r_cent_q;
    logic [SW-1:0]      r_sum_q;

    logic               w_accept;
    logic               w_pt_we;
    logic               w_cent_ld;
    logic               w_cent_we;
    logic [CW+DW-1:0]   w_cent_wa;
    logic [COORD_W-1:0] w_cent_wd;
    logic [CW+DW-1:0]   w_sum_ra;
    logic [SW-1:0]      w_sum_old;
    logic [SW-1:0]      w_sum_new;
    logic [CW-1:0]      w_cnt_idx;
    logic [CNW-1:0]     w_cnt_sel;
    logic [PIW-1:0]     w_last_pt;
    logic [CW-1:0]      w_last_cl;
    logic [DW-1:0]      w_last_dim;
    logic               w_j_last;
    logic               w_c_last;
    logic [MAG_W-1:0]   w_diff;
    logic [MAG_W-1:0]   w_diff_mag;
    logic [DIST_W-1:0]  w_dist_new;
    logic               w_any_empty;
    logic [SW-1:0]      w_div_num;
    logic               w_div_done;
    logic [SW-1:0]      w_div_quot;
    logic [COORD_W-1:0] w_q32;
    logic [MAG_W-1:0]   w_q_ext;
    logic [MAG_W-1:0]   w_old_ext;
    logic               w_sq_start;
    logic [RAD_W-1:0]   w_sq_rad;
    logic               w_sq_done;
    logic [RTW-1:0]     w_sq_root;
    logic [RTW-1:0]     w_norm_diff;
    logic [ITER_W-1:0]  w_pass_inc;

    assign o_busy   = (r_state != S_IDLE);
    assign w_accept = i_start && !o_busy;

    // clamped loop bounds, held as last index
    always_comb begin
        if (r_num_points == '0) begin
            w_last_pt = '0;
        end else if (32'(r_num_points) >= MAX_POINTS) begin
            w_last_pt = PIW'(MAX_POINTS - 1);
        end else begin
            w_last_pt = PIW'(r_num_points - 11'd1);
        end
        if (r_num_clusters == '0) begin
            w_last_cl = '0;
        end else if (32'(r_num_clusters) >= MAX_CLUSTERS) begin
            w_last_cl = CW'(MAX_CLUSTERS - 1);
        end else begin
            w_last_cl = CW'(r_num_clusters - 4'd1);
        end
        if (r_num_dims == '0) begin
            w_last_dim = '0;
        end else if (32'(r_num_dims) >= MAX_DIMS) begin
            w_last_dim = DW'(MAX_DIMS - 1);
        end else begin
            w_last_dim = DW'(r_num_dims - 4'd1);
        end
    end

    assign w_j_last = (r_j == w_last_dim);
    assign w_c_last = (r_c == w_last_cl);

    // loads that fall outside the stores are dropped
    assign w_pt_we   = w_accept && (i_operation == OP_LOAD_POINT)
                       && (32'(i_row) < MAX_POINTS) && (32'(i_dim) < MAX_DIMS);
    assign w_cent_ld = w_accept && (i_operation == OP_LOAD_CENTROID)
                       && (32'(i_row) < MAX_CLUSTERS) && (32'(i_dim) < MAX_DIMS);

    // centroid write: host load while idle, or new mean during the update
    assign w_cent_we = w_cent_ld || ((r_state == S_UDIV) && w_div_done);
    assign w_cent_wa = w_cent_ld ? {CW'(i_row), DW'(i_dim)} : {r_c, r_j};
    assign w_cent_wd = w_cent_ld ? i_coord : w_q32;

    // sums are read by best cluster while accumulating, by cluster while updating
    assign w_sum_ra  = ((r_state == S_ARD) || (r_state == S_AWR)) ? {r_best, r_j} : {r_c, r_j};
    assign w_cnt_idx = (r_state == S_UOLD) ? r_c : r_best;
    assign w_cnt_sel = r_cnt[w_cnt_idx];

    always_ff @(posedge i_clk) begin
        if (w_pt_we) begin
            r_pt_mem[{PIW'(i_row), DW'(i_dim)}] <= i_coord;
        end
        r_pt_q <= r_pt_mem[{r_i, r_j}];
    end

    always_ff @(posedge i_clk) begin
        if (w_cent_we) begin
            r_cent_mem[w_cent_wa] <= w_cent_wd;
        end
        r_cent_q <= r_cent_mem[{r_c, r_j}];
    end

    // read in S_ARD, written back in S_AWR; every read that is used comes
    // after the write of its entry, so no forwarding is needed
    always_ff @(posedge i_clk) begin
        if (r_state == S_AWR) begin
            r_sum_mem[{r_best, r_j}] <= w_sum_new;
        end
        r_sum_q <= r_sum_mem[w_sum_ra];
    end

    // first member of a cluster in this pass starts its sum from zero
    assign w_sum_old = (w_cnt_sel == '0) ? '0 : r_sum_q;
    assign w_sum_new = w_sum_old + {{(SW - COORD_W){r_pt_q[COORD_W-1]}}, r_pt_q};

    // distance term: |p - c| on 33 bits
    assign w_diff     = {r_pt_q[COORD_W-1], r_pt_q} - {r_cent_q[COORD_W-1], r_cent_q};
    assign w_diff_mag = w_diff[MAG_W-1] ? (MAG_W'(0) - w_diff) : w_diff;
    assign w_dist_new = r_dist + DIST_W'(r_prod);

    always_comb begin
        w_any_empty = 1'b0;
        for (int c = 0; c < MAX_CLUSTERS; c++) begin
            if ((CW'(c) <= w_last_cl) && (r_cnt[c] == '0)) begin
                w_any_empty = 1'b1;
            end
        end
    end

    // mean, truncated toward zero, kept to 32 bits
    assign w_div_num = r_sum_q[SW-1] ? (SW'(0) - r_sum_q) : r_sum_q;
    assign w_q32     = r_neg ? (COORD_W'(0) - w_div_quot[COORD_W-1:0])
                             : w_div_quot[COORD_W-1:0];
    assign w_q_ext   = {w_q32[COORD_W-1], w_q32};
    assign w_old_ext = {r_cent_q[COORD_W-1], r_cent_q};

    km_div #(
        .NUM_W (SW),
        .DEN_W (CNW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_UOLD),
        .i_num   (w_div_num),
        .i_den   (w_cnt_sel),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // one root unit, run on the old norm then the new one
    assign w_sq_start = ((r_state == S_UNACC) && w_j_last) || ((r_state == S_SQO) && w_sq_done);
    assign w_sq_rad   = (r_state == S_SQO) ? r_s_new : r_s_old;

    km_isqrt #(
        .RAD_W (RAD_W)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_rad   (w_sq_rad),
        .o_done  (w_sq_done),
        .o_root  (w_sq_root)
    );

    assign w_norm_diff = (r_norm_old > w_sq_root) ? (r_norm_old - w_sq_root)
                                                  : (w_sq_root - r_norm_old);
    assign w_pass_inc  = r_pass + 1'b1;

    // single shared squarer
    always_ff @(posedge i_clk) begin
        r_prod <= r_mul_a * r_mul_a;
    end

    // configuration port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_points   <= 11'd1;
            r_num_clusters <= 4'd1;
            r_num_dims     <= 4'd1;
            r_max_iter     <= 16'd300;
            r_epsilon      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_NUM_POINTS:   r_num_points   <= i_cfg_data[10:0];
                CFG_NUM_CLUSTERS: r_num_clusters <= i_cfg_data[3:0];
                CFG_NUM_DIMS:     r_num_dims     <= i_cfg_data[3:0];
                CFG_MAX_ITER:     r_max_iter     <= i_cfg_data[ITER_W-1:0];
                CFG_EPSILON:      r_epsilon      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_pass  <= '0;
            r_empty <= 1'b0;
            r_i     <= '0;
            r_c     <= '0;
            r_j     <= '0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_operation == OP_RUN)) begin
                        r_pass  <= '0;
                        r_empty <= 1'b0;
                        r_i     <= '0;
                        r_c     <= '0;
                        r_j     <= '0;
                        for (int c = 0; c < MAX_CLUSTERS; c++) begin
                            r_cnt[c] <= '0;
                        end
                        // a zero pass limit emits the loaded centroids
                        r_state <= (r_max_iter == '0) ? S_ERD : S_DRD;
                    end
                end
                // assignment: distance of point i to centroid c, one coordinate at a time
                S_DRD:  r_state <= S_DSUB;
                S_DSUB: r_state <= S_DMUL;
                S_DMUL: r_state <= S_DACC;
                S_DACC: begin
                    if (w_j_last) begin
                        r_j <= '0;
                        if (w_c_last) begin
                            r_state <= S_ARD;
                        end else begin
                            r_c     <= r_c + 1'b1;
                            r_state <= S_DRD;
                        end
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_DRD;
                    end
                end
                // accumulate point i into the sums of its cluster
                S_ARD: r_state <= S_AWR;
                S_AWR: begin
                    if (w_j_last) begin
                        r_j           <= '0;
                        r_c           <= '0;
                        r_cnt[r_best] <= r_cnt[r_best] + 1'b1;
                        if (r_i == w_last_pt) begin
                            r_state <= S_CHK;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_DRD;
                        end
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_ARD;
                    end
                end
                S_CHK: begin
                    r_c <= '0;
                    r_j <= '0;
                    if (w_any_empty) begin
                        // pass dropped, centroids unchanged
                        r_empty <= 1'b1;
                        r_state <= S_ERD;
                    end else begin
                        r_state <= S_URD;
                    end
                end
                // update: old value feeds the old norm, mean feeds the new one
                S_URD:  r_state <= S_UOLD;
                S_UOLD: r_state <= S_UDIV;
                S_UDIV: begin
                    if (w_div_done) begin
                        r_state <= S_UNMUL;
                    end
                end
                S_UNMUL: r_state <= S_UNACC;
                S_UNACC: begin
                    if (w_j_last) begin
                        r_j     <= '0;
                        r_state <= S_SQO;
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_URD;
                    end
                end
                S_SQO: begin
                    if (w_sq_done) begin
                        r_state <= S_SQN;
                    end
                end
                S_SQN: begin
                    if (w_sq_done) begin
                        if (w_c_last) begin
                            r_state <= S_PEND;
                        end else begin
                            r_c     <= r_c + 1'b1;
                            r_state <= S_URD;
                        end
                    end
                end
                S_PEND: begin
                    r_pass <= w_pass_inc;
                    r_i    <= '0;
                    r_c    <= '0;
                    r_j    <= '0;
                    if (r_conv || (w_pass_inc >= r_max_iter)) begin
                        r_state <= S_ERD;
                    end else begin
                        for (int c = 0; c < MAX_CLUSTERS; c++) begin
                            r_cnt[c] <= '0;
                        end
                        r_state <= S_DRD;
                    end
                end
                // emit centroids cluster-major
                S_ERD: r_state <= S_EOUT;
                S_EOUT: begin
                    r_valid <= 1'b1;
                    if (w_j_last) begin
                        r_j <= '0;
                        if (w_c_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_c     <= r_c + 1'b1;
                            r_state <= S_ERD;
                        end
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_ERD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_dist <= '0;
            end
            S_DSUB: begin
                r_mul_a <= w_diff_mag;
            end
            S_DACC: begin
                if (w_j_last) begin
                    r_dist <= '0;
                    // strict compare keeps the lowest index on a tie
                    if ((r_c == '0) || (w_dist_new < r_best_dist)) begin
                        r_best      <= r_c;
                        r_best_dist <= w_dist_new;
                    end
                end else begin
                    r_dist <= w_dist_new;
                end
            end
            S_CHK: begin
                r_conv  <= 1'b1;
                r_s_old <= '0;
                r_s_new <= '0;
            end
            S_UOLD: begin
                r_mul_a <= w_old_ext[MAG_W-1] ? (MAG_W'(0) - w_old_ext) : w_old_ext;
                r_neg   <= r_sum_q[SW-1];
            end
            S_UDIV: begin
                if (w_div_done) begin
                    r_s_old <= r_s_old + r_prod;
                    r_mul_a <= w_q_ext[MAG_W-1] ? (MAG_W'(0) - w_q_ext) : w_q_ext;
                end
            end
            S_UNACC: begin
                r_s_new <= r_s_new + r_prod;
            end
            S_SQO: begin
                if (w_sq_done) begin
                    r_norm_old <= w_sq_root;
                end
            end
            S_SQN: begin
                if (w_sq_done) begin
                    r_s_old <= '0;
                    r_s_new <= '0;
                    if (w_norm_diff >= RTW'(r_epsilon)) begin
                        r_conv <= 1'b0;
                    end
                end
            end
            S_PEND: begin
                r_dist <= '0;
            end
            S_EOUT: begin
                r_out_cl   <= CL_W'(r_c);
                r_out_dim  <= DIM_W'(r_j);
                r_out_val  <= r_cent_q;
                r_out_last <= w_j_last && w_c_last;
            end
            default: ;
        endcase
    end

    assign o_valid          = r_valid;
    assign o_cluster        = r_out_cl;
    assign o_coord_index    = r_out_dim;
    assign o_centroid_value = r_out_val;
    assign o_iterations     = r_pass;
    assign o_empty_error    = r_empty;
    assign o_last           = r_out_last;
endmodule

// ===== rtl/core/km_div.sv =====
// iterative restoring divider, one quotient bit per cycle
// depends on nothing but its parameters
module km_div #(
    parameter int NUM_W = 42,
    parameter int DEN_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W:0]   w_rem_sh;
    logic             w_fit;

    assign w_rem_sh = {r_rem, r_quo[NUM_W-1]};
    assign w_fit    = (w_rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_fit ? DEN_W'(w_rem_sh - {1'b0, r_den}) : DEN_W'(w_rem_sh);
            r_quo <= {r_quo[NUM_W-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
endmodule

// ===== rtl/core/km_isqrt.sv =====
// iterative integer square root, floor, one root bit per cycle
// depends on nothing but its parameters
module km_isqrt #(
    parameter int RAD_W = 66
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [RAD_W-1:0]     i_rad,
    output logic                 o_done,
    output logic [RAD_W/2-1:0]   o_root
);
    localparam int RW    = RAD_W / 2;
    localparam int CNT_W = $clog2(RW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [RAD_W-1:0] r_rad;
    logic [RW+1:0]    r_rem;
    logic [RW-1:0]    r_root;
    logic [RW+1:0]    w_rem_sh;
    logic [RW+1:0]    w_trial;
    logic             w_fit;

    assign w_rem_sh = {r_rem[RW-1:0], r_rad[RAD_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_fit    = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(RW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_rem  <= w_fit ? (w_rem_sh - w_trial) : w_rem_sh;
            r_root <= {r_root[RW-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// ===== rtl/core/km_checker.sv =====
// port-level checks on the k-means engine, bound to its top level
// depends on km_pkg and assert_macros.svh
`include "assert_macros.svh"

module km_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_start,
    input logic                              o_busy,
    input logic [km_pkg::OP_W-1:0]           i_operation,
    input logic                              o_valid,
    input logic                              o_last
);
    import km_pkg::*;

    // a run command always leaves idle on the next cycle
    `KM_ASSERT_NXT(a_run_busy, i_start && !o_busy && (i_operation == OP_RUN), o_busy)
    // loads and unused codes never occupy the engine
    `KM_ASSERT_NXT(a_load_idle, i_start && !o_busy && (i_operation != OP_RUN), !o_busy)
    // no two results come back to back
    `KM_ASSERT_NXT(a_result_gap, o_valid, !o_valid)
    // only the final result may show while idle
    `KM_ASSERT_IMP(a_result_busy, o_valid && !o_last, o_busy)
endmodule

bind kmeans_clustering km_checker u_km_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_operation (i_operation),
    .o_valid     (o_valid),
    .o_last      (o_last)
);

// ===== sim/tb_kmeans_clustering.sv =====
`timescale 1ns / 100ps
// self-checking testbench of the k-means engine: directed table, then random load/run sets
// depends on km_pkg and kmeans_clustering; everything else is built in
module tb_kmeans_clustering;
    import km_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // one emitted centroid coordinate
    typedef struct {
        logic [2:0]         cl;
        logic [2:0]         ci;
        logic signed [31:0] val;
        logic [15:0]        iters;
        logic               err;
        logic               last;
    } t_centroid_out;

    // one command transfer
    typedef struct {
        logic [OP_W-1:0] op;
        logic [9:0]      row;
        logic [2:0]      dim;
        logic [31:0]     coord;
    } t_cmd;

    // one row of the directed table: config write or command, typed result optional
    typedef struct {
        bit                 is_cfg;
        t_cfg_idx           idx;
        logic [31:0]        data;
        t_cmd               cmd;
        bit                 typed;
        logic signed [31:0] val;
        logic [15:0]        iters;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [OP_W-1:0]    i_operation = '0;
    logic [ROW_W-1:0]   i_row = '0;
    logic [DIM_W-1:0]   i_dim = '0;
    logic signed [COORD_W-1:0] i_coord = '0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        o_valid;
    logic [CL_W-1:0]  o_cluster;
    logic [DIM_W-1:0] o_coord_index;
    logic signed [COORD_W-1:0] o_centroid_value;
    logic [ITER_W-1:0] o_iterations;
    logic        o_empty_error;
    logic        o_last;

    kmeans_clustering DUT (.*);

    always #1 i_clk = ~i_clk;

    // hard stop, so that a hung run ends the simulation with an error
    initial begin
        #4000000;
        $display("[kmeans_clustering] ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // predictor state: stores and registers as the block holds them
    // ---------------------------------------------------------------
    int          point_mem [KM_MAX_POINTS][KM_MAX_DIMS];
    int          cent_cur  [KM_MAX_CLUSTERS][KM_MAX_DIMS];
    int          cent_prev [KM_MAX_CLUSTERS][KM_MAX_DIMS];
    logic [10:0] reg_points = 11'd1;
    logic [3:0]  reg_clusters = 4'd1;
    logic [3:0]  reg_dims = 4'd1;
    logic [15:0] reg_max_iter = 16'd300;
    logic [31:0] reg_eps = 32'd0;

    t_centroid_out centroid_q[$];   // centroid coordinates still to come
    int errors = 0;
    int n_runs = 0, n_results = 0, n_empty = 0, n_converged = 0, n_items = 0;
    bit took = 1'b0;                // command transfer happened at the last rising edge

    function automatic int clamp_reg(int v, int hi);
        return v < 1 ? 1 : (v > hi ? hi : v);
    endfunction

    // square of the magnitude of a signed difference, wide enough for the sums
    function automatic logic [69:0] sq_mag(longint v);
        logic [69:0] m;
        m = (v < 0) ? 70'(-v) : 70'(v);
        return m * m;
    endfunction

    // floor of the root of the sum of squared coordinates, units of 2^-16
    function automatic longint centroid_norm(bit prev, int c, int d);
        logic [69:0] s, t;
        longint r;
        s = '0;
        r = 0;
        for (int j = 0; j < d; j++)
            s += sq_mag(prev ? cent_prev[c][j] : cent_cur[c][j]);
        for (int b = 34; b >= 0; b--) begin
            t = 70'(r | (longint'(1) << b));
            if (t * t <= s) r = longint'(t);
        end
        return r;
    endfunction

    // one assignment and update pass; status 0 go on, 1 converged, 2 empty cluster
    task automatic kmeans_pass(int n, int k, int d, output int status, inout int passes);
        longint      sums [KM_MAX_CLUSTERS][KM_MAX_DIMS];
        int          cnt  [KM_MAX_CLUSTERS];
        int          best;
        logic [69:0] cand_dist, best_dist;
        longint      a, b;
        bit          conv;
        for (int c = 0; c < KM_MAX_CLUSTERS; c++) begin
            cnt[c] = 0;
            for (int j = 0; j < KM_MAX_DIMS; j++) sums[c][j] = 0;
        end
        for (int i = 0; i < n; i++) begin
            best = 0;
            best_dist = '0;
            for (int c = 0; c < k; c++) begin
                cand_dist = '0;
                for (int j = 0; j < d; j++)
                    cand_dist += sq_mag(longint'(point_mem[i][j]) - longint'(cent_cur[c][j]));
                // strict compare keeps ties on the lowest index
                if (c == 0 || cand_dist < best_dist) begin
                    best = c;
                    best_dist = cand_dist;
                end
            end
            cnt[best]++;
            for (int j = 0; j < d; j++) sums[best][j] += point_mem[i][j];
        end
        status = 0;
        for (int c = 0; c < k; c++)
            if (cnt[c] == 0) status = 2;
        if (status == 0) begin
            // signed division truncates toward zero
            for (int c = 0; c < k; c++)
                for (int j = 0; j < d; j++)
                    cent_cur[c][j] = int'(sums[c][j] / longint'(cnt[c]));
            conv = 1'b1;
            for (int c = 0; c < k; c++) begin
                a = centroid_norm(1'b1, c, d);
                b = centroid_norm(1'b0, c, d);
                if ((a > b ? a - b : b - a) >= longint'({32'd0, reg_eps})) conv = 1'b0;
            end
            passes++;
            cent_prev = cent_cur;
            status = conv ? 1 : 0;
        end
    endtask

    // advance the model by one accepted command and collect the centroids it emits
    task automatic kmeans_predict(t_cmd cmd, ref t_centroid_out outs[$]);
        int n, k, d, status, passes;
        t_centroid_out r;
        outs.delete();
        case (cmd.op)
            OP_LOAD_POINT: point_mem[cmd.row][cmd.dim] = cmd.coord;
            OP_LOAD_CENTROID:
                if (cmd.row < KM_MAX_CLUSTERS) cent_cur[cmd.row][cmd.dim] = cmd.coord;
            OP_RUN: begin
                n = clamp_reg(reg_points, KM_MAX_POINTS);
                k = clamp_reg(reg_clusters, KM_MAX_CLUSTERS);
                d = clamp_reg(reg_dims, KM_MAX_DIMS);
                cent_prev = cent_cur;
                passes = 0;
                status = 0;
                while (status == 0 && passes < reg_max_iter)
                    kmeans_pass(n, k, d, status, passes);
                n_runs++;
                if (status == 2) n_empty++;
                if (status == 1) n_converged++;
                for (int c = 0; c < k; c++)
                    for (int j = 0; j < d; j++) begin
                        r.cl    = 3'(c);
                        r.ci    = 3'(j);
                        r.val   = cent_cur[c][j];
                        r.iters = 16'(passes);
                        r.err   = (status == 2);
                        r.last  = (c == k - 1 && j == d - 1);
                        outs.push_back(r);
                    end
            end
            default: ;  // unused code is ignored
        endcase
    endtask

    // ---------------------------------------------------------------
    // result checking: every strobe is matched against the oldest expectation
    // ---------------------------------------------------------------
    task automatic check_field(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t mismatch %s: expected %0d (0x%0h) actual %0d (0x%0h)",
                     $time, name, want, want, got, got);
            errors++;
        end
    endtask

    t_centroid_out head;

    always @(posedge i_clk) begin
        took <= i_rst_n && i_start && !o_busy;
        if (i_rst_n && o_valid) begin
            if (centroid_q.size() == 0) begin
                $display("%0t unexpected result: expected none actual cluster %0d coord %0d",
                         $time, o_cluster, o_coord_index);
                errors++;
            end else begin
                head = centroid_q.pop_front();
                n_results++;
                check_field("cluster", head.cl, o_cluster);
                check_field("coord_index", head.ci, o_coord_index);
                check_field("centroid_value", head.val, o_centroid_value);
                check_field("iterations", head.iters, o_iterations);
                check_field("empty_error", head.err, o_empty_error);
                check_field("last", head.last, o_last);
            end
        end
    end

    // ---------------------------------------------------------------
    // drivers: all inputs change on the falling edge, from this process only
    // ---------------------------------------------------------------

    // hold start until the transfer is taken; start stays high for a back-to-back item
    task automatic send_cmd(t_cmd cmd, int gap, bit typed = 0,
                            logic signed [31:0] tval = 0, logic [15:0] titer = 0);
        t_centroid_out outs[$];
        t_centroid_out t;
        if (gap > 0) begin
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_operation = cmd.op;
        i_row       = cmd.row;
        i_dim       = cmd.dim;
        i_coord     = cmd.coord;
        i_start     = 1'b1;
        kmeans_predict(cmd, outs);
        if (typed) begin
            // single-coordinate run whose answer is known by inspection
            t = '{cl: 3'd0, ci: 3'd0, val: tval, iters: titer, err: 1'b0, last: 1'b1};
            centroid_q.push_back(t);
        end else begin
            foreach (outs[i]) centroid_q.push_back(outs[i]);
        end
        @(negedge i_clk);
        while (!took) @(negedge i_clk);
    endtask

    // let every expected result arrive, then the tail of the block's work
    task automatic wait_idle();
        i_start = 1'b0;
        while (centroid_q.size() != 0 || o_busy) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [31:0] data);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        case (idx)
            CFG_NUM_POINTS:   reg_points   = data[10:0];
            CFG_NUM_CLUSTERS: reg_clusters = data[3:0];
            CFG_NUM_DIMS:     reg_dims     = data[3:0];
            CFG_MAX_ITER:     reg_max_iter = data[15:0];
            CFG_EPSILON:      reg_eps      = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // directed table
    // ---------------------------------------------------------------
    t_dir_row dir_tab[$];

    task automatic add_cfg(t_cfg_idx idx, logic [31:0] data);
        t_dir_row r;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        r.cmd    = '{op: '0, row: '0, dim: '0, coord: '0};
        r.typed  = 1'b0;
        r.val    = '0;
        r.iters  = '0;
        dir_tab.push_back(r);
    endtask

    task automatic add_cmd(logic [OP_W-1:0] op, int row, int dim, logic [31:0] coord,
                           bit typed = 0, logic signed [31:0] val = 0, int iters = 0);
        t_dir_row r;
        r.is_cfg = 1'b0;
        r.idx    = CFG_NUM_POINTS;
        r.data   = '0;
        r.cmd   = '{op: op, row: 10'(row), dim: 3'(dim), coord: coord};
        r.typed = typed;
        r.val   = val;
        r.iters = 16'(iters);
        dir_tab.push_back(r);
    endtask

    task automatic build_directed();
        // zero pass limit emits the loaded centroid untouched
        add_cfg(CFG_MAX_ITER, 32'd0);
        add_cmd(OP_LOAD_POINT, 0, 0, 32'h7FFF_FFFF);
        add_cmd(OP_LOAD_CENTROID, 0, 0, 32'h8000_0000);
        add_cmd(OP_RUN, 0, 0, 32'd0, 1, 32'h8000_0000, 0);
        // one pass from the most negative centroid to the most positive point
        add_cfg(CFG_MAX_ITER, 32'd1);
        add_cmd(OP_RUN, 0, 0, 32'd0, 1, 32'h7FFF_FFFF, 1);
        // widest epsilon converges on the first pass despite the largest pass limit
        add_cfg(CFG_MAX_ITER, 32'h0000_FFFF);
        add_cfg(CFG_EPSILON, 32'hFFFF_FFFF);
        add_cmd(OP_LOAD_CENTROID, 0, 0, 32'd0);
        add_cmd(OP_RUN, 0, 0, 32'd0, 1, 32'h7FFF_FFFF, 1);
        // second centroid far away gets no member: empty cluster abort
        add_cfg(CFG_NUM_CLUSTERS, 32'd2);
        add_cmd(OP_LOAD_CENTROID, 1, 0, 32'h8000_0000);
        add_cmd(OP_RUN, 0, 0, 32'd0);
        // point at 0 is equally far from +1 and -1: tie goes to cluster 0
        add_cmd(OP_LOAD_POINT, 1, 0, 32'hFFFB_0000);
        add_cmd(OP_LOAD_POINT, 0, 0, 32'd0);
        add_cmd(OP_LOAD_CENTROID, 0, 0, 32'h0001_0000);
        add_cmd(OP_LOAD_CENTROID, 1, 0, 32'hFFFF_0000);
        add_cfg(CFG_NUM_POINTS, 32'd2);
        add_cmd(OP_RUN, 0, 0, 32'd0);
        // ignored: unused code and centroid row beyond the last cluster
        add_cmd(OP_UNUSED, 1023, 7, 32'hFFFF_FFFF);
        add_cmd(OP_LOAD_CENTROID, 1023, 7, 32'h1234_5678);
        // zero point, cluster and dimension counts are used as one
        add_cfg(CFG_NUM_CLUSTERS, 32'd0);
        add_cfg(CFG_NUM_DIMS, 32'd0);
        add_cfg(CFG_NUM_POINTS, 32'd0);
        add_cfg(CFG_EPSILON, 32'd0);
        add_cfg(CFG_MAX_ITER, 32'd3);
        add_cmd(OP_RUN, 0, 0, 32'd0);
    endtask

    // ---------------------------------------------------------------
    // random load/run sets
    // ---------------------------------------------------------------
    function automatic int small_signed(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // one complete set: registers, every point and centroid in use, noise, then a run
    task automatic random_set(bit bulk);
        t_cmd loads[$];
        t_cmd c;
        int   n, k, d, tmp, burst, gap;
        int   centre [KM_MAX_CLUSTERS][KM_MAX_DIMS];
        bit   raw;
        logic [10:0] np_w;
        logic [3:0]  k_w, d_w;
        logic [15:0] it_w;
        logic [31:0] eps_w;

        wait_idle();
        if (bulk) begin
            // largest point count: register above the top is used as the top
            np_w = 11'd2047; k_w = 4'd2; d_w = 4'd1; it_w = 16'd2; eps_w = 32'd0;
        end else begin
            np_w = 11'($urandom_range(1, 12));
            k_w  = 4'($urandom_range(1, 4));
            d_w  = 4'($urandom_range(1, 4));
            case ($urandom_range(9))
                0: begin np_w = 11'd8; k_w = 4'd15; d_w = 4'd15; end   // clamped to 8 x 8
                1: begin k_w = 4'd0; d_w = 4'd8; end
                2: k_w = 4'd8;
                default: ;
            endcase
            case ($urandom_range(9))
                0: begin it_w = 16'd0; eps_w = $urandom(); end
                1: begin it_w = 16'hFFFF; eps_w = 32'hFFFF_FFFF; end
                2, 3: begin it_w = 16'($urandom_range(1, 4)); eps_w = $urandom(); end
                default: begin
                    it_w  = 16'($urandom_range(1, 4));
                    eps_w = 32'($urandom_range(0, 32'h0004_0000));
                end
            endcase
        end
        write_cfg(CFG_NUM_POINTS, {$urandom() & 32'hFFFF_F800} | 32'(np_w));
        write_cfg(CFG_NUM_CLUSTERS, 32'(k_w));
        write_cfg(CFG_NUM_DIMS, 32'(d_w));
        write_cfg(CFG_MAX_ITER, 32'(it_w));
        write_cfg(CFG_EPSILON, eps_w);
        n = clamp_reg(np_w, KM_MAX_POINTS);
        k = clamp_reg(k_w, KM_MAX_CLUSTERS);
        d = clamp_reg(d_w, KM_MAX_DIMS);

        // well-formed sets cluster around k centres; the rest use the full range
        raw = !bulk && ($urandom_range(4) == 0);
        for (int cc = 0; cc < k; cc++)
            for (int j = 0; j < d; j++) centre[cc][j] = small_signed(32'h0010_0000);
        for (int i = 0; i < n; i++)
            for (int j = 0; j < d; j++) begin
                c.op  = OP_LOAD_POINT;
                c.row = 10'(i);
                c.dim = 3'(j);
                c.coord = raw ? $urandom() : 32'(centre[i % k][j] + small_signed(32'h4000));
                point_mem[i][j] = 0;
                loads.push_back(c);
            end
        // initial centroids copy the first points where there are enough of them
        for (int cc = 0; cc < k; cc++)
            for (int j = 0; j < d; j++) begin
                c.op  = OP_LOAD_CENTROID;
                c.row = 10'(cc);
                c.dim = 3'(j);
                c.coord = (cc < n && !raw) ? loads[cc * d + j].coord : $urandom();
                loads.push_back(c);
            end
        if (!bulk)
            for (int i = loads.size() - 1; i > 0; i--) begin
                tmp = $urandom_range(i);
                c = loads[i];
                loads[i] = loads[tmp];
                loads[tmp] = c;
            end

        burst = bulk || ($urandom_range(2) == 0);
        foreach (loads[i]) begin
            gap = burst ? 0 : $urandom_range(10);
            if ($urandom_range(11) == 0) begin
                // noise the block must ignore
                c.op    = ($urandom_range(1) == 0) ? OP_UNUSED : OP_LOAD_CENTROID;
                c.row   = 10'($urandom_range(KM_MAX_CLUSTERS, 1023));
                c.dim   = 3'($urandom());
                c.coord = $urandom();
                send_cmd(c, gap);
            end
            send_cmd(loads[i], gap);
            n_items++;
        end
        c = '{op: OP_RUN, row: 10'($urandom()), dim: 3'($urandom()), coord: $urandom()};
        send_cmd(c, burst ? 0 : $urandom_range(10));
        n_items++;
        i_start = 1'b0;
    endtask

    initial begin
        foreach (point_mem[i, j]) point_mem[i][j] = 0;
        foreach (cent_cur[i, j]) begin
            cent_cur[i][j]  = 0;
            cent_prev[i][j] = 0;
        end
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        build_directed();
        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg) begin
                // registers only change with the block at rest
                wait_idle();
                write_cfg(dir_tab[i].idx, dir_tab[i].data);
            end else begin
                send_cmd(dir_tab[i].cmd, $urandom_range(3), dir_tab[i].typed,
                         dir_tab[i].val, dir_tab[i].iters);
                n_items++;
            end
        end

        while (n_items < 350) random_set(1'b0);

        wait_idle();
        repeat (50) @(negedge i_clk);
        $display("covered %0d runs (%0d converged, %0d empty-cluster aborts), %0d results checked",
                 n_runs, n_converged, n_empty, n_results);
        $display("register extremes, clamped sizes, ignored commands and tie breaks included");
        if (errors == 0 && centroid_q.size() == 0) begin
            $display("[kmeans_clustering] OK");
        end else begin
            $display("[kmeans_clustering] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/km_pkg.sv
rtl/core/km_div.sv
rtl/core/km_isqrt.sv
rtl/core/kmeans_clustering.sv
rtl/core/km_checker.sv
sim/tb_kmeans_clustering.sv
